>>> src/dlrr_pkg.sv
`timescale 1ns / 1ps

package dlrr_pkg;

    // Slice table geometry
    localparam int SLICE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(SLICE_ENTRIES);
    localparam int ACT_MAX       = (SLICE_ENTRIES < 256) ? SLICE_ENTRIES : 256;
    localparam int ACT_W         = $clog2(ACT_MAX + 1);
    localparam int CMP_W         = ((IDX_W > ACT_W) ? IDX_W : ACT_W) + 1;

    // Input operations
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_CMD  = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    // Command opcodes
    localparam logic [7:0] OPC_SETTIMG = 8'h20;
    localparam logic [7:0] OPC_DLREF   = 8'h31;
    localparam logic [7:0] OPC_VTXREF  = 8'h32;
    localparam logic [7:0] OPC_MARKER  = 8'h33;
    localparam logic [7:0] OPC_MOVEMEM = 8'h42;
    localparam logic [7:0] SEG_0E      = 8'h0E;
    localparam logic [7:0] OPC_ENDDL   = 8'hDF;
    localparam logic [7:0] OPC_DL      = 8'hDE;
    localparam logic [7:0] OPC_TIMG    = 8'hFD;
    localparam logic [7:0] OPC_MM      = 8'hDC;
    localparam logic [7:0] OPC_VTX     = 8'h01;
    localparam logic [23:0] LOW24      = 24'hFFFFFF;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_HASH   = 2'd1;
    localparam logic [1:0] ST_NO_MM     = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    // Configuration register indexes
    localparam logic REG_SLICE_COUNT  = 1'b0;
    localparam logic REG_VANILLA_SIZE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISP,
        S_HASH,
        S_BIN
    } state_t;

    typedef enum logic [2:0] {
        PK_NONE,
        PK_MARKER,
        PK_VTX,
        PK_DL,
        PK_TIMG,
        PK_MM
    } pend_t;

    typedef struct packed {
        logic [31:0] first;
        logic [31:0] second;
        logic        patch;
        logic [7:0]  slice;
        logic [31:0] addend;
        logic        seg;
    } pair_t;

    typedef struct packed {
        logic        pair_valid;
        pair_t       pair;
        logic [1:0]  status;
        logic        last;
    } result_t;

endpackage

>>> src/display_list_reference_rewriter.sv
`timescale 1ns / 1ps

// Display list reference rewriter. Load requests (op 0) write the slice table.
// A command request that needs no lookup passes through the dispatch state
// back to idle. A hash reference walks the active entries of the slice table
// (at most 256) one entry per cycle through its single read port. A segment
// 0x0E literal does a binary search over the table. End of list (op 2) emits
// the closing result. One request is processed at a time and a new one is
// taken only once the previous result has been collected. Configuration writes
// are always accepted.
module display_list_reference_rewriter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [31:0] s_command_hi,
    input  logic [31:0] s_command_lo,
    input  logic [7:0]  s_entry_index,
    input  logic [23:0] s_entry_offset,
    input  logic [23:0] s_entry_size,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_pair_valid,
    output logic [31:0] m_word_first,
    output logic [31:0] m_word_second,
    output logic        m_is_patch,
    output logic [7:0]  m_dest_slice,
    output logic [31:0] m_addend,
    output logic        m_segment_form,
    output logic [1:0]  m_status,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data
);

    // Slice table
    logic [63:0] hash_mem [dlrr_pkg::SLICE_ENTRIES];
    logic [23:0] off_mem  [dlrr_pkg::SLICE_ENTRIES];
    logic [23:0] size_mem [dlrr_pkg::SLICE_ENTRIES];
    logic [63:0] rd_hash_reg;
    logic [23:0] rd_off_reg;
    logic [23:0] rd_size_reg;

    logic [8:0]  entry_count_reg;
    logic [23:0] vanilla_size_reg;

    dlrr_pkg::state_t state_reg, state_next;
    dlrr_pkg::pend_t  pend_reg, pend_next;
    logic [63:0] pend_cmd_reg, pend_cmd_next;
    logic        skip_reg, skip_next;
    dlrr_pkg::pair_t held_reg, held_next;
    logic        held_valid_reg, held_valid_next;
    logic [23:0] wc_reg, wc_next;
    logic [1:0]  error_reg, error_next;
    logic        m_valid_reg, m_valid_next;
    dlrr_pkg::result_t out_reg, out_next;

    logic [31:0] cmd_hi_reg, cmd_hi_next;
    logic [31:0] cmd_lo_reg, cmd_lo_next;
    logic [dlrr_pkg::IDX_W-1:0] addr_reg, addr_next;
    logic [dlrr_pkg::ACT_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [31:0] sr_first_reg, sr_first_next;
    logic [31:0] sr_addend_reg, sr_addend_next;
    logic [31:0] sr_word_reg, sr_word_next;

    logic [dlrr_pkg::ACT_W-1:0] n_act;
    logic s_acc;

    // Combinational working values
    logic        push_en, fail_en;
    logic [1:0]  fail_code;
    dlrr_pkg::pair_t push_pair;
    logic [7:0]  opc, branch, real_opc;
    logic        dup;
    logic [31:0] pw0, pw1, lit_first, lit_word;
    logic [dlrr_pkg::ACT_W:0] mid_sum;
    logic [24:0] slice_end;
    logic [1:0]  err_eff;
    logic        term;

    assign s_ready   = (state_reg == dlrr_pkg::S_IDLE) && !m_valid_reg;
    assign s_acc     = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign n_act = (entry_count_reg > 9'(dlrr_pkg::ACT_MAX)) ?
                   dlrr_pkg::ACT_W'(dlrr_pkg::ACT_MAX) :
                   dlrr_pkg::ACT_W'(entry_count_reg);

    assign m_valid        = m_valid_reg;
    assign m_pair_valid   = out_reg.pair_valid;
    assign m_word_first   = out_reg.pair.first;
    assign m_word_second  = out_reg.pair.second;
    assign m_is_patch     = out_reg.pair.patch;
    assign m_dest_slice   = out_reg.pair.slice;
    assign m_addend       = out_reg.pair.addend;
    assign m_segment_form = out_reg.pair.seg;
    assign m_status       = out_reg.status;
    assign m_last         = out_reg.last;

    // Table write and registered read
    always_ff @(posedge aclk) begin
        if (s_acc && s_op == dlrr_pkg::OP_LOAD &&
            13'(s_entry_index) < 13'(dlrr_pkg::SLICE_ENTRIES)) begin
            hash_mem[dlrr_pkg::IDX_W'(s_entry_index)] <= {s_command_hi, s_command_lo};
            off_mem[dlrr_pkg::IDX_W'(s_entry_index)]  <= s_entry_offset;
            size_mem[dlrr_pkg::IDX_W'(s_entry_index)] <= s_entry_size;
        end
        rd_hash_reg <= hash_mem[addr_next];
        rd_off_reg  <= off_mem[addr_next];
        rd_size_reg <= size_mem[addr_next];
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg  <= '0;
            vanilla_size_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == dlrr_pkg::REG_SLICE_COUNT) begin
                entry_count_reg <= cfg_data[8:0];
            end else begin
                vanilla_size_reg <= cfg_data;
            end
        end
    end

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dlrr_pkg::S_IDLE;
            pend_reg       <= dlrr_pkg::PK_NONE;
            pend_cmd_reg   <= '0;
            skip_reg       <= 1'b0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            wc_reg         <= '0;
            error_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_reg       <= pend_next;
            pend_cmd_reg   <= pend_cmd_next;
            skip_reg       <= skip_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            wc_reg         <= wc_next;
            error_reg      <= error_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        out_reg       <= out_next;
        cmd_hi_reg    <= cmd_hi_next;
        cmd_lo_reg    <= cmd_lo_next;
        addr_reg      <= addr_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        sr_first_reg  <= sr_first_next;
        sr_addend_reg <= sr_addend_next;
        sr_word_reg   <= sr_word_next;
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        pend_next       = pend_reg;
        pend_cmd_next   = pend_cmd_reg;
        skip_next       = skip_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        wc_next         = wc_reg;
        error_next      = error_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_next        = out_reg;
        cmd_hi_next     = cmd_hi_reg;
        cmd_lo_next     = cmd_lo_reg;
        addr_next       = addr_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        sr_first_next   = sr_first_reg;
        sr_addend_next  = sr_addend_reg;
        sr_word_next    = sr_word_reg;
        push_en         = 1'b0;
        push_pair       = '0;
        fail_en         = 1'b0;
        fail_code       = dlrr_pkg::ST_OK;

        opc       = cmd_hi_reg[31:24];
        pw0       = pend_cmd_reg[63:32];
        pw1       = pend_cmd_reg[31:0];
        branch    = pw0[23:16];
        dup       = (cmd_hi_reg == pw0) && (cmd_lo_reg == pw1);
        real_opc  = (pend_reg == dlrr_pkg::PK_DL)   ? dlrr_pkg::OPC_DL :
                    (pend_reg == dlrr_pkg::PK_TIMG) ? dlrr_pkg::OPC_TIMG :
                                                      dlrr_pkg::OPC_MM;
        lit_word  = dup ? pw1 : cmd_lo_reg;
        lit_first = dup ? {real_opc, (pend_reg == dlrr_pkg::PK_TIMG) ? pw0[23:0] : 24'd0}
                        : cmd_hi_reg;
        mid_sum   = '0;
        slice_end = {1'b0, rd_off_reg} + {1'b0, rd_size_reg};
        err_eff   = error_reg;
        term      = 1'b0;

        unique case (state_reg)
            dlrr_pkg::S_IDLE: begin
                if (s_acc && s_op == dlrr_pkg::OP_CMD && error_reg == dlrr_pkg::ST_OK) begin
                    cmd_hi_next = s_command_hi;
                    cmd_lo_next = s_command_lo;
                    state_next  = dlrr_pkg::S_DISP;
                end else if (s_acc && s_op == dlrr_pkg::OP_END) begin
                    if (error_reg == dlrr_pkg::ST_OK && pend_reg != dlrr_pkg::PK_NONE &&
                        pend_reg != dlrr_pkg::PK_MARKER) begin
                        err_eff = dlrr_pkg::ST_TRUNCATED;
                    end
                    term = (held_reg.first == {dlrr_pkg::OPC_ENDDL, 24'd0}) &&
                           (held_reg.patch || held_reg.second == 32'd0) &&
                           ({wc_reg, 2'b00} == {2'b00, vanilla_size_reg} + 26'd8);
                    out_next = '0;
                    out_next.status = err_eff;
                    out_next.last   = 1'b1;
                    if (err_eff == dlrr_pkg::ST_OK && held_valid_reg && !term) begin
                        out_next.pair_valid = 1'b1;
                        out_next.pair       = held_reg;
                    end
                    m_valid_next    = 1'b1;
                    pend_next       = dlrr_pkg::PK_NONE;
                    pend_cmd_next   = '0;
                    skip_next       = 1'b0;
                    held_next       = '0;
                    held_valid_next = 1'b0;
                    wc_next         = '0;
                    error_next      = dlrr_pkg::ST_OK;
                end
            end

            dlrr_pkg::S_DISP: begin
                state_next = dlrr_pkg::S_IDLE;
                if (pend_reg == dlrr_pkg::PK_NONE) begin
                    skip_next = 1'b0;
                    if (skip_reg && opc == dlrr_pkg::OPC_ENDDL) begin
                        // dropped end after a no-push branch
                    end else if (opc == dlrr_pkg::OPC_MARKER) begin
                        pend_next = dlrr_pkg::PK_MARKER;
                    end else if (opc == dlrr_pkg::OPC_VTXREF || opc == dlrr_pkg::OPC_DLREF ||
                                 opc == dlrr_pkg::OPC_SETTIMG ||
                                 opc == dlrr_pkg::OPC_MOVEMEM) begin
                        pend_next = (opc == dlrr_pkg::OPC_VTXREF)  ? dlrr_pkg::PK_VTX :
                                    (opc == dlrr_pkg::OPC_DLREF)   ? dlrr_pkg::PK_DL :
                                    (opc == dlrr_pkg::OPC_SETTIMG) ? dlrr_pkg::PK_TIMG :
                                                                     dlrr_pkg::PK_MM;
                        pend_cmd_next = {cmd_hi_reg, cmd_lo_reg};
                    end else begin
                        push_en          = 1'b1;
                        push_pair.first  = cmd_hi_reg;
                        push_pair.second = cmd_lo_reg;
                    end
                end else begin
                    pend_next = dlrr_pkg::PK_NONE;
                    if (pend_reg == dlrr_pkg::PK_DL) begin
                        skip_next = branch[0];
                    end
                    addr_next = '0;
                    if (pend_reg == dlrr_pkg::PK_MARKER) begin
                        // operand skipped
                    end else if (pend_reg == dlrr_pkg::PK_VTX) begin
                        sr_first_next  = {dlrr_pkg::OPC_VTX, 4'd0, pw0[19:12], 4'd0,
                                          pw0[7:1], 1'b0};
                        sr_addend_next = pw1;
                        state_next     = dlrr_pkg::S_HASH;
                    end else if (dup || opc == real_opc) begin
                        if (pend_reg == dlrr_pkg::PK_MM) begin
                            fail_en   = 1'b1;
                            fail_code = dlrr_pkg::ST_NO_MM;
                        end else if (lit_word[31:24] == dlrr_pkg::SEG_0E && n_act != '0) begin
                            sr_first_next = lit_first;
                            sr_word_next  = lit_word;
                            lo_next       = '0;
                            hi_next       = n_act;
                            mid_sum       = {1'b0, n_act};
                            addr_next     = dlrr_pkg::IDX_W'(mid_sum >> 1);
                            state_next    = dlrr_pkg::S_BIN;
                        end else begin
                            push_en          = 1'b1;
                            push_pair.first  = lit_first;
                            push_pair.second = lit_word;
                        end
                    end else begin
                        sr_addend_next = '0;
                        if (pend_reg == dlrr_pkg::PK_DL) begin
                            sr_first_next = {dlrr_pkg::OPC_DL, branch, 16'd0};
                        end else if (pend_reg == dlrr_pkg::PK_TIMG) begin
                            sr_first_next = {dlrr_pkg::OPC_TIMG, pw0[23:0]};
                        end else begin
                            sr_first_next = {dlrr_pkg::OPC_MM, pw0[23:0]};
                            if (pw1[15:8] != 8'd0) begin
                                sr_addend_next = 32'd8;
                            end
                        end
                        state_next = dlrr_pkg::S_HASH;
                    end
                end
            end

            // Linear walk, one entry per cycle
            dlrr_pkg::S_HASH: begin
                if (n_act == '0) begin
                    fail_en    = 1'b1;
                    fail_code  = dlrr_pkg::ST_NO_HASH;
                    state_next = dlrr_pkg::S_IDLE;
                end else if (rd_hash_reg == {cmd_hi_reg, cmd_lo_reg}) begin
                    push_en          = 1'b1;
                    push_pair.first  = sr_first_reg;
                    push_pair.patch  = 1'b1;
                    push_pair.slice  = 8'(addr_reg);
                    push_pair.addend = sr_addend_reg;
                    state_next       = dlrr_pkg::S_IDLE;
                end else if (dlrr_pkg::CMP_W'(addr_reg) + dlrr_pkg::CMP_W'(1) >=
                             dlrr_pkg::CMP_W'(n_act)) begin
                    fail_en    = 1'b1;
                    fail_code  = dlrr_pkg::ST_NO_HASH;
                    state_next = dlrr_pkg::S_IDLE;
                end else begin
                    addr_next = addr_reg + dlrr_pkg::IDX_W'(1);
                end
            end

            // Binary search for the slice holding the offset
            dlrr_pkg::S_BIN: begin
                if (sr_word_reg[23:0] < rd_off_reg) begin
                    hi_next = dlrr_pkg::ACT_W'(addr_reg);
                end else if ({1'b0, sr_word_reg[23:0]} >= slice_end) begin
                    lo_next = dlrr_pkg::ACT_W'(addr_reg) + dlrr_pkg::ACT_W'(1);
                end else begin
                    push_en          = 1'b1;
                    push_pair.first  = sr_first_reg;
                    push_pair.patch  = 1'b1;
                    push_pair.slice  = 8'(addr_reg);
                    push_pair.addend = {8'd0, sr_word_reg[23:0] - rd_off_reg};
                    push_pair.seg    = 1'b1;
                    state_next       = dlrr_pkg::S_IDLE;
                end
                if (!push_en) begin
                    if (lo_next < hi_next) begin
                        mid_sum   = {1'b0, lo_next} + {1'b0, hi_next};
                        addr_next = dlrr_pkg::IDX_W'(mid_sum >> 1);
                    end else begin
                        push_en          = 1'b1;
                        push_pair.first  = sr_first_reg;
                        push_pair.second = sr_word_reg;
                        state_next       = dlrr_pkg::S_IDLE;
                    end
                end
            end

            default: state_next = dlrr_pkg::S_IDLE;
        endcase

        // New pair: release the held one, hold the new one
        if (push_en) begin
            if (held_valid_reg) begin
                out_next            = '0;
                out_next.pair_valid = 1'b1;
                out_next.pair       = held_reg;
                m_valid_next        = 1'b1;
            end
            held_next       = push_pair;
            held_valid_next = 1'b1;
            wc_next         = (wc_reg >= dlrr_pkg::LOW24 - 24'd1) ? dlrr_pkg::LOW24
                                                                 : wc_reg + 24'd2;
        end

        // Sticky error
        if (fail_en) begin
            if (error_reg == dlrr_pkg::ST_OK) begin
                error_next = fail_code;
            end
            held_valid_next = 1'b0;
            pend_next       = dlrr_pkg::PK_NONE;
        end
    end

endmodule

>>> src/dlrr_checker.sv
`timescale 1ns / 1ps

module dlrr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_pair_valid,
    input logic [31:0] m_word_first,
    input logic [31:0] m_word_second,
    input logic        m_is_patch,
    input logic [1:0]  m_status,
    input logic        m_last
);

    // Stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word_first) && $stable(m_last))
        else $error("result changed while stalled");

    // Patch results carry no literal second word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_patch |-> m_pair_valid && m_word_second == 32'd0)
        else $error("patch with second word");

    // Errors only appear on the closing result, without a pair
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != 2'd0 |-> m_last && !m_pair_valid)
        else $error("error status on a pair result");

    // Empty results are only the closing one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_pair_valid |-> m_last)
        else $error("empty result before end of list");

endmodule

bind display_list_reference_rewriter dlrr_checker u_dlrr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_pair_valid  (m_pair_valid),
    .m_word_first  (m_word_first),
    .m_word_second (m_word_second),
    .m_is_patch    (m_is_patch),
    .m_status      (m_status),
    .m_last        (m_last)
);

>>> sim/tb_display_list_reference_rewriter.sv
`timescale 1ns / 1ps

module tb_display_list_reference_rewriter;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam logic [31:0] END_WORD   = {dlrr_pkg::OPC_ENDDL, 24'h0};
    localparam logic [7:0]  PLAIN_OPC  = 8'hE7;
    localparam int          SETTLE     = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = dlrr_pkg::OP_LOAD;
    logic [31:0] s_command_hi = '0;
    logic [31:0] s_command_lo = '0;
    logic [7:0]  s_entry_index = '0;
    logic [23:0] s_entry_offset = '0;
    logic [23:0] s_entry_size = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_pair_valid;
    logic [31:0] m_word_first;
    logic [31:0] m_word_second;
    logic        m_is_patch;
    logic [7:0]  m_dest_slice;
    logic [31:0] m_addend;
    logic        m_segment_form;
    logic [1:0]  m_status;
    logic        m_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = dlrr_pkg::REG_SLICE_COUNT;
    logic [23:0] cfg_data = '0;

    display_list_reference_rewriter u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_command_hi   (s_command_hi),
        .s_command_lo   (s_command_lo),
        .s_entry_index  (s_entry_index),
        .s_entry_offset (s_entry_offset),
        .s_entry_size   (s_entry_size),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pair_valid   (m_pair_valid),
        .m_word_first   (m_word_first),
        .m_word_second  (m_word_second),
        .m_is_patch     (m_is_patch),
        .m_dest_slice   (m_dest_slice),
        .m_addend       (m_addend),
        .m_segment_form (m_segment_form),
        .m_status       (m_status),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #100ms;
        $display("Timeout at %0t", $time);
        $display("== FAIL ==");
        $finish;
    end

    // Rewriter state as predicted
    logic [63:0] tab_hash [256];
    int unsigned tab_off [256];
    int unsigned tab_size [256];
    int unsigned model_count;
    int unsigned model_vsize;
    dlrr_pkg::pend_t model_pend;
    logic [63:0] model_pend_cmd;
    bit          model_skip;
    dlrr_pkg::pair_t model_held;
    bit          model_held_v;
    int unsigned model_wc;
    logic [1:0]  model_err;

    dlrr_pkg::result_t expected_results[$];
    int failures;
    int items_sent;
    int results_seen;
    int lists_done;
    int cfg_writes;
    int send_idle_pct;
    int stall_pct;

    function automatic int unsigned active_slices();
        return (model_count > 256) ? 256 : model_count;
    endfunction

    function automatic void clear_list_state();
        model_pend     = dlrr_pkg::PK_NONE;
        model_pend_cmd = '0;
        model_skip     = 1'b0;
        model_held     = '0;
        model_held_v   = 1'b0;
        model_wc       = 0;
        model_err      = dlrr_pkg::ST_OK;
    endfunction

    function automatic void queue_held(bit with_pair, bit fin);
        dlrr_pkg::result_t r;
        r = '0;
        r.pair_valid = with_pair;
        if (with_pair)
            r.pair = model_held;
        r.status = model_err;
        r.last   = fin;
        expected_results.insert(expected_results.size(), r);
    endfunction

    // New pair goes into the hold slot; the previous one is released
    function automatic void hold_pair(logic [31:0] first, logic [31:0] second, bit patch,
                                      int unsigned slice, logic [31:0] addend, bit seg);
        if (model_held_v)
            queue_held(1'b1, 1'b0);
        model_held.first  = first;
        model_held.second = patch ? 32'h0 : second;
        model_held.patch  = patch;
        model_held.slice  = patch ? slice[7:0] : 8'h0;
        model_held.addend = patch ? addend : 32'h0;
        model_held.seg    = patch && seg;
        model_held_v      = 1'b1;
        model_wc = (model_wc >= 32'hFFFFFE) ? 32'hFFFFFF : model_wc + 2;
    endfunction

    function automatic bit match_hash(logic [63:0] h, output int unsigned s);
        s = 0;
        for (int unsigned i = 0; i < active_slices(); i++) begin
            if (tab_hash[i] == h) begin
                s = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Binary search for the slice holding a byte offset
    function automatic bit containing_slice(int unsigned off, output int unsigned s);
        int unsigned lo_i, hi_i, mid;
        lo_i = 0;
        hi_i = active_slices();
        s = 0;
        while (lo_i < hi_i) begin
            mid = (lo_i + hi_i) / 2;
            if (off < tab_off[mid]) begin
                hi_i = mid;
            end else if (off >= tab_off[mid] + tab_size[mid]) begin
                lo_i = mid + 1;
            end else begin
                s = mid;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void hold_literal(logic [31:0] first, logic [31:0] w1);
        int unsigned s;
        if (w1[31:24] == dlrr_pkg::SEG_0E && containing_slice(32'(w1[23:0]), s))
            hold_pair(first, 32'h0, 1'b1, s, 32'(w1[23:0]) - tab_off[s], 1'b1);
        else
            hold_pair(first, w1, 1'b0, 0, 32'h0, 1'b0);
    endfunction

    function automatic void raise_error(logic [1:0] code);
        if (model_err == dlrr_pkg::ST_OK)
            model_err = code;
        model_held_v = 1'b0;
        model_pend   = dlrr_pkg::PK_NONE;
    endfunction

    function automatic void rewrite_command(logic [31:0] hi, logic [31:0] lo);
        dlrr_pkg::pend_t kind;
        logic [31:0] pw0, pw1, first, addend;
        logic [7:0]  opc, real_opc, branch;
        int unsigned s;
        bit          dup;
        kind = model_pend;
        pw0  = model_pend_cmd[63:32];
        pw1  = model_pend_cmd[31:0];
        opc  = hi[31:24];
        if (kind == dlrr_pkg::PK_NONE) begin
            if (model_skip && opc == dlrr_pkg::OPC_ENDDL) begin
                model_skip = 1'b0;
                return;
            end
            model_skip = 1'b0;
            if (opc == dlrr_pkg::OPC_MARKER) begin
                model_pend = dlrr_pkg::PK_MARKER;
                return;
            end
            if (opc == dlrr_pkg::OPC_VTXREF)       model_pend = dlrr_pkg::PK_VTX;
            else if (opc == dlrr_pkg::OPC_DLREF)   model_pend = dlrr_pkg::PK_DL;
            else if (opc == dlrr_pkg::OPC_SETTIMG) model_pend = dlrr_pkg::PK_TIMG;
            else if (opc == dlrr_pkg::OPC_MOVEMEM) model_pend = dlrr_pkg::PK_MM;
            else begin
                hold_pair(hi, lo, 1'b0, 0, 32'h0, 1'b0);
                return;
            end
            model_pend_cmd = {hi, lo};
            return;
        end
        model_pend = dlrr_pkg::PK_NONE;
        if (kind == dlrr_pkg::PK_MARKER)
            return;
        if (kind == dlrr_pkg::PK_VTX) begin
            first = {dlrr_pkg::OPC_VTX, 24'h0} | ({24'h0, pw0[19:12]} << 12) |
                    ({25'h0, pw0[7:1]} << 1);
            if (!match_hash({hi, lo}, s)) begin
                raise_error(dlrr_pkg::ST_NO_HASH);
                return;
            end
            hold_pair(first, 32'h0, 1'b1, s, pw1, 1'b0);
            return;
        end
        real_opc = (kind == dlrr_pkg::PK_DL)   ? dlrr_pkg::OPC_DL :
                   (kind == dlrr_pkg::PK_TIMG) ? dlrr_pkg::OPC_TIMG : dlrr_pkg::OPC_MM;
        dup      = (hi == pw0) && (lo == pw1);
        branch   = pw0[23:16];
        if (dup || opc == real_opc) begin
            if (kind == dlrr_pkg::PK_MM) begin
                raise_error(dlrr_pkg::ST_NO_MM);
                return;
            end
            if (dup)
                hold_literal({real_opc, (kind == dlrr_pkg::PK_TIMG) ? pw0[23:0] : 24'h0},
                             pw1);
            else
                hold_literal(hi, lo);
        end else begin
            if (!match_hash({hi, lo}, s)) begin
                raise_error(dlrr_pkg::ST_NO_HASH);
                return;
            end
            addend = 32'h0;
            if (kind == dlrr_pkg::PK_DL) begin
                first = {dlrr_pkg::OPC_DL, branch, 16'h0};
            end else if (kind == dlrr_pkg::PK_TIMG) begin
                first = {dlrr_pkg::OPC_TIMG, pw0[23:0]};
            end else begin
                first  = {dlrr_pkg::OPC_MM, pw0[23:0]};
                addend = (pw1[15:8] != 8'h0) ? 32'd8 : 32'd0;
            end
            hold_pair(first, 32'h0, 1'b1, s, addend, 1'b0);
        end
        // no-push branch swallows a following end-of-DL
        if (kind == dlrr_pkg::PK_DL)
            model_skip = branch[0];
    endfunction

    function automatic void close_list();
        bit term;
        if (model_err == dlrr_pkg::ST_OK && model_pend != dlrr_pkg::PK_NONE &&
            model_pend != dlrr_pkg::PK_MARKER)
            raise_error(dlrr_pkg::ST_TRUNCATED);
        if (model_err != dlrr_pkg::ST_OK || !model_held_v) begin
            queue_held(1'b0, 1'b1);
        end else begin
            term = model_held.first == END_WORD && (model_held.patch || model_held.second == 0);
            queue_held(!(term && model_wc * 4 == model_vsize + 8), 1'b1);
        end
        clear_list_state();
    endfunction

    function automatic void rewrite_request(logic [1:0] op, logic [31:0] hi, logic [31:0] lo,
                                            logic [7:0] idx, logic [23:0] off, logic [23:0] sz);
        case (op)
            dlrr_pkg::OP_LOAD: begin
                tab_hash[idx] = {hi, lo};
                tab_off[idx]  = 32'(off);
                tab_size[idx] = 32'(sz);
            end
            dlrr_pkg::OP_CMD: begin
                if (model_err == dlrr_pkg::ST_OK)
                    rewrite_command(hi, lo);
            end
            dlrr_pkg::OP_END: close_list();
            default: ;
        endcase
    endfunction

    // Result checker and receiver stalls
    function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin
        dlrr_pkg::result_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual first word %h",
                         $time, m_word_first);
                failures++;
            end else begin
                e = expected_results.pop_front();
                compare_field("pair_valid", 32'(e.pair_valid), 32'(m_pair_valid));
                compare_field("word_first", e.pair.first, m_word_first);
                compare_field("word_second", e.pair.second, m_word_second);
                compare_field("is_patch", 32'(e.pair.patch), 32'(m_is_patch));
                compare_field("dest_slice", 32'(e.pair.slice), 32'(m_dest_slice));
                compare_field("addend", e.pair.addend, m_addend);
                compare_field("segment_form", 32'(e.pair.seg), 32'(m_segment_form));
                compare_field("status", 32'(e.status), 32'(m_status));
                compare_field("last", 32'(e.last), 32'(m_last));
            end
        end
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // One request on the input channel
    task automatic send_request(logic [1:0] op, logic [31:0] hi, logic [31:0] lo,
                                logic [7:0] idx, logic [23:0] off, logic [23:0] sz);
        s_valid        <= 1'b1;
        s_op           <= op;
        s_command_hi   <= hi;
        s_command_lo   <= lo;
        s_entry_index  <= idx;
        s_entry_offset <= off;
        s_entry_size   <= sz;
        do @(posedge aclk); while (!s_ready);
        if (op != OP_RESERVED && !(op == dlrr_pkg::OP_CMD && model_err != dlrr_pkg::ST_OK))
            items_sent++;
        rewrite_request(op, hi, lo, idx, off, sz);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    task automatic send_cmd(logic [31:0] hi, logic [31:0] lo);
        send_request(dlrr_pkg::OP_CMD, hi, lo, 8'($urandom), 24'($urandom), 24'($urandom));
    endtask

    task automatic send_end();
        send_request(dlrr_pkg::OP_END, $urandom, $urandom, 8'($urandom), 24'($urandom),
                     24'($urandom));
        lists_done++;
    endtask

    task automatic send_reserved();
        send_request(OP_RESERVED, $urandom, $urandom, 8'($urandom), 24'($urandom),
                     24'($urandom));
    endtask

    task automatic send_load(logic [7:0] idx, logic [63:0] h, logic [23:0] off, logic [23:0] sz);
        send_request(dlrr_pkg::OP_LOAD, h[63:32], h[31:0], idx, off, sz);
    endtask

    task automatic send_hash_of(int unsigned i);
        send_cmd(tab_hash[i][63:32], tab_hash[i][31:0]);
    endtask

    // Operand hash: a table hit unless an error is wanted
    task automatic send_hash(int err_pct);
        if (active_slices() > 0 && $urandom_range(0, 99) >= err_pct)
            send_hash_of($urandom_range(0, active_slices() - 1));
        else
            send_cmd($urandom, $urandom);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_config(int unsigned count, int unsigned vsize);
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= dlrr_pkg::REG_SLICE_COUNT;
        cfg_data  <= 24'(count);
        do @(posedge aclk); while (!cfg_ready);
        model_count = count;
        cfg_index <= dlrr_pkg::REG_VANILLA_SIZE;
        cfg_data  <= 24'(vsize);
        do @(posedge aclk); while (!cfg_ready);
        model_vsize = vsize & 32'hFFFFFF;
        cfg_valid <= 1'b0;
        cfg_writes += 2;
    endtask

    function automatic logic [7:0] any_pseudo(bit allow_mm);
        case ($urandom_range(0, allow_mm ? 3 : 2))
            0:       return dlrr_pkg::OPC_SETTIMG;
            1:       return dlrr_pkg::OPC_DLREF;
            2:       return dlrr_pkg::OPC_VTXREF;
            default: return dlrr_pkg::OPC_MOVEMEM;
        endcase
    endfunction

    function automatic logic [7:0] real_of(logic [7:0] pseudo);
        case (pseudo)
            dlrr_pkg::OPC_DLREF:   return dlrr_pkg::OPC_DL;
            dlrr_pkg::OPC_SETTIMG: return dlrr_pkg::OPC_TIMG;
            default:               return dlrr_pkg::OPC_MM;
        endcase
    endfunction

    // Segment 0x0E word, mostly inside an active slice
    function automatic logic [31:0] seg_word();
        int unsigned s, off;
        if (active_slices() > 0 && $urandom_range(0, 3) != 0) begin
            s   = $urandom_range(0, active_slices() - 1);
            off = tab_off[s] + $urandom_range(0, tab_size[s] - 1);
            return {dlrr_pkg::SEG_0E, off[23:0]};
        end
        off = $urandom;
        return {dlrr_pkg::SEG_0E, off[23:0]};
    endfunction

    // A well-formed list with random content; errors at err_pct
    task automatic run_list(int parts, int err_pct);
        int          r;
        logic [7:0]  p;
        logic [31:0] w0, w1;
        for (int k = 0; k < parts; k++) begin
            r  = $urandom_range(0, 99);
            w0 = $urandom;
            w1 = $urandom;
            if (r < 25) begin
                send_cmd(w0, w1);
            end else if (r < 45) begin
                w0[31:24] = any_pseudo(1'b1);
                send_cmd(w0, w1);
                send_hash(err_pct);
            end else if (r < 55) begin
                w0[31:24] = ($urandom_range(0, 99) < err_pct) ? dlrr_pkg::OPC_MOVEMEM
                                                              : any_pseudo(1'b0);
                if (w0[31:24] == dlrr_pkg::OPC_VTXREF)
                    w0[31:24] = dlrr_pkg::OPC_DLREF;
                if ($urandom_range(0, 1))
                    w1 = seg_word();
                send_cmd(w0, w1);
                send_cmd(w0, w1);
            end else if (r < 65) begin
                p = ($urandom_range(0, 99) < err_pct) ? dlrr_pkg::OPC_MOVEMEM : any_pseudo(1'b0);
                if (p == dlrr_pkg::OPC_VTXREF)
                    p = dlrr_pkg::OPC_SETTIMG;
                w0[31:24] = p;
                send_cmd(w0, w1);
                w0 = $urandom;
                w0[31:24] = real_of(p);
                send_cmd(w0, seg_word());
            end else if (r < 75) begin
                send_cmd(w0, seg_word());
            end else if (r < 82) begin
                w0[31:24] = dlrr_pkg::OPC_MARKER;
                send_cmd(w0, w1);
                send_cmd($urandom, $urandom);
            end else if (r < 92) begin
                w0[31:24] = dlrr_pkg::OPC_DLREF;
                w0[16]    = 1'b1;
                send_cmd(w0, w1);
                send_hash(err_pct);
                if ($urandom_range(0, 9) < 7)
                    send_cmd(END_WORD, 32'h0);
            end else begin
                send_cmd(END_WORD, $urandom_range(0, 1) ? 32'h0 : $urandom);
            end
        end
        // Pad to the size that makes a closing end-of-DL droppable
        if ($urandom_range(0, 9) < 4 && model_vsize <= 8 * 40) begin
            while (model_err == dlrr_pkg::ST_OK && model_wc * 4 < model_vsize)
                send_cmd({PLAIN_OPC, 24'($urandom)}, $urandom);
            if (model_wc * 4 == model_vsize)
                send_cmd(END_WORD, 32'h0);
        end
        // Occasionally leave a pseudo-opcode without its operand
        if ($urandom_range(0, 99) < err_pct) begin
            w0 = $urandom;
            w0[31:24] = ($urandom_range(0, 3) == 0) ? dlrr_pkg::OPC_MARKER : any_pseudo(1'b1);
            send_cmd(w0, $urandom);
        end
        send_end();
    endtask

    // Table fill: ascending offsets, every entry written
    task automatic test_table_load();
        for (int i = 0; i < 256; i++)
            send_load(8'(i), {$urandom, $urandom}, 24'(i * 256), 24'($urandom_range(1, 255)));
        write_config(4, 8);
    endtask

    task automatic test_directed_lists();
        // field extremes in the table: zero hash, zero offset, top entry at the ceiling
        send_load(8'd0, 64'h0, 24'h0, 24'h40);
        send_load(8'd255, {64{1'b1}}, 24'hFFFFFF, 24'hFFFFFF);
        // list with every kind of reference
        send_cmd(32'hFFFFFFFF, 32'hFFFFFFFF);
        send_cmd(32'h0, 32'h0);
        send_cmd({dlrr_pkg::OPC_VTXREF, 24'h0A5FE}, 32'h40);
        send_hash_of(1);
        send_cmd({dlrr_pkg::OPC_DLREF, 8'h01, 16'h0}, 32'h0);
        send_hash_of(2);
        send_cmd(END_WORD, 32'h0);
        send_cmd({dlrr_pkg::OPC_SETTIMG, 24'h123456}, {dlrr_pkg::SEG_0E, 24'h000010});
        send_cmd({dlrr_pkg::OPC_SETTIMG, 24'h123456}, {dlrr_pkg::SEG_0E, 24'h000010});
        send_cmd({dlrr_pkg::OPC_MOVEMEM, 24'h000777}, 32'h5);
        send_cmd({dlrr_pkg::OPC_MM, 24'h0A0B0C}, {dlrr_pkg::SEG_0E, 24'hFFFF00});
        send_cmd({dlrr_pkg::OPC_MOVEMEM, 24'h020304}, 32'h0000_0100);
        send_hash_of(3);
        send_cmd({dlrr_pkg::OPC_MARKER, 24'h0}, 32'h0);
        send_cmd({dlrr_pkg::OPC_VTXREF, 24'h0}, 32'h1);
        // sender holds back until everything is out
        wait_drained();
        send_reserved();
        send_cmd(END_WORD, 32'h0);
        send_end();
        // terminator dropped on a size match
        send_cmd(32'h0600_0000, 32'h1);
        send_cmd(END_WORD, 32'h0);
        send_end();
        // empty list
        send_end();
        // unresolved hash, then ignored commands
        send_cmd({dlrr_pkg::OPC_DLREF, 24'h0}, 32'h0);
        send_cmd(32'h1234_5678, 32'h9ABC_DEF0);
        send_cmd(32'h0100_0000, 32'h0);
        send_end();
        // operand missing at end of list
        send_cmd(32'h0200_0000, 32'h0);
        send_cmd({dlrr_pkg::OPC_VTXREF, 24'h0}, 32'h0);
        send_end();
        // pending skip marker at end of list
        send_cmd({dlrr_pkg::OPC_MARKER, 24'h0}, 32'h0);
        send_end();
        // movemem literal cannot be resolved
        send_cmd({dlrr_pkg::OPC_MOVEMEM, 24'h1}, 32'h2);
        send_cmd({dlrr_pkg::OPC_MOVEMEM, 24'h1}, 32'h2);
        send_end();
    endtask

    task automatic test_random_lists(int send_pct, int recv_pct, int unsigned base_count,
                                     int unsigned base_vsize, int quota);
        int          goal;
        int          n;
        int          slot;
        int unsigned vs;
        goal = items_sent + quota;
        n    = 0;
        wait_drained();
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        write_config(base_count, base_vsize);
        while (items_sent < goal) begin
            if (n % 8 == 7) begin
                vs = ($urandom_range(0, 3) == 0) ? ($urandom & 32'hFFFFFF)
                                                 : 8 * $urandom_range(0, 10);
                write_config(($urandom_range(0, 2) == 0) ? base_count : $urandom_range(1, 32), vs);
            end
            // noise between lists: reserved op or a table reload in place
            if ($urandom_range(0, 4) == 0)
                send_reserved();
            if ($urandom_range(0, 4) == 0) begin
                slot = $urandom_range(0, 254);
                send_load(8'(slot), {$urandom, $urandom}, 24'(slot * 256),
                          24'($urandom_range(1, 255)));
            end
            run_list($urandom_range(0, 12), 4);
            n++;
        end
    endtask

    initial begin
        clear_list_state();
        model_count   = 0;
        model_vsize   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_table_load();
        test_directed_lists();
        test_random_lists(0, 0, 8, 24, 420);
        test_random_lists(86, 0, 256, 24'hFFFFFF, 300);
        test_random_lists(0, 86, 0, 0, 420);
        test_random_lists(34, 34, 16, 40, 420);

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            failures++;
        end
        $display("Sent %0d requests in %0d lists, checked %0d results, %0d register writes",
                 items_sent, lists_done, results_seen, cfg_writes);
        $display("Idling phases: none, sender, receiver, both; slice counts 0 to 256");
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
